// File: rtl/core/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared types and constants of the P6 stream parser: result kinds, error
// codes, header character codes and the operation passed from parser to
// result emitter.
// ----------------------------------------------------------------------------
package ppm_pkg;

  localparam int DIM_BITS_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int MAXVAL_REQ = 255;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_MAGIC  = 3'd1,
    ERR_TRUNCATED  = 3'd2,
    ERR_BAD_WIDTH  = 3'd3,
    ERR_BAD_HEIGHT = 3'd4,
    ERR_BAD_MAXVAL = 3'd5,
    ERR_SHORT_DATA = 3'd6
  } err_t;

  typedef struct packed {
    logic        has_header;
    logic        has_pixel;
    logic        has_error;
    err_t        err;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  pixel;
    logic        last;
  } ppm_op_t;

endpackage

// File: rtl/core/ppm_intf.sv
// ----------------------------------------------------------------------------
// ppm_intf
// Valid/ready channels of the P6 stream parser: the file byte stream and
// the result stream.
// ----------------------------------------------------------------------------
interface ppm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface ppm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] frame_width;
  logic [15:0] frame_height;
  logic [7:0]  pixel_byte;
  logic [2:0]  error_code;
  logic        last_pixel;

  modport source (output valid, output kind, output frame_width, output frame_height,
                  output pixel_byte, output error_code, output last_pixel, input ready);
  modport sink   (input valid, input kind, input frame_width, input frame_height,
                  input pixel_byte, input error_code, input last_pixel, output ready);
endinterface

// File: rtl/core/ppm_front.sv
// ----------------------------------------------------------------------------
// ppm_front
// Header parser: takes one file byte per cycle while the queue has room,
// tracks the parse phase, the decimal fields and the pixel byte count,
// and issues one operation per item that causes results.
// ----------------------------------------------------------------------------
module ppm_front
  import ppm_pkg::*;
#(
  parameter int DIM_BITS = DIM_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ppm_in_if.sink     file_bytes,
  output logic       op_valid,
  input  logic       op_ready,
  output ppm_op_t    op
);

  localparam int MAC_W = DIM_BITS + 4;
  localparam int CNT_W = 2 * DIM_BITS + 2;
  localparam int PRD_W = 2 * DIM_BITS;
  localparam logic [DIM_BITS-1:0] DIM_MAX = '1;
  localparam logic [1:0] FLD_WIDTH  = 2'd0;
  localparam logic [1:0] FLD_HEIGHT = 2'd1;

  typedef enum logic [3:0] {
    PH_MAGIC1,
    PH_MAGIC2,
    PH_SKIP,
    PH_COMMENT,
    PH_NUMBER,
    PH_AFTER_MAX,
    PH_AFTER_CR,
    PH_DATA,
    PH_DONE,
    PH_ERROR
  } phase_t;

  phase_t              phase, phase_next;
  logic [1:0]          field, field_next;
  logic [DIM_BITS-1:0] acc, acc_next;
  logic [DIM_BITS-1:0] width_store, width_next;
  logic [DIM_BITS-1:0] height_store, height_next;
  logic [CNT_W-1:0]    remaining, remain_next;
  logic [PRD_W-1:0]    product;
  logic [CNT_W-1:0]    total;

  logic [7:0]          b;
  logic                take;
  logic                is_digit, is_hash, is_ws, is_other;
  logic [3:0]          digit;
  logic [MAC_W-1:0]    acc_mac;
  logic [DIM_BITS-1:0] acc_sat;
  logic                is_fw, is_fh, is_fmax, check;
  logic [DIM_BITS-1:0] v0, w_fin, h_fin, m_fin;
  logic                hdr_emit, pix_emit, err_emit, to_after_max;
  err_t                err_code;
  logic [CNT_W-1:0]    base, dec;

  assign b        = file_bytes.in_byte;
  assign take     = file_bytes.valid && file_bytes.ready;
  assign file_bytes.ready = op_ready;

  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_hash  = (b == CH_HASH);
  assign is_ws    = (b <= CH_SPACE);
  assign is_other = !is_digit && !is_hash && !is_ws;
  assign digit    = 4'(b - CH_ZERO);

  assign acc_mac = (MAC_W'(acc) << 3) + (MAC_W'(acc) << 1) + MAC_W'(digit);
  assign acc_sat = (acc_mac > MAC_W'(DIM_MAX)) ? DIM_MAX : acc_mac[DIM_BITS-1:0];

  assign is_fw   = (field == FLD_WIDTH);
  assign is_fh   = (field == FLD_HEIGHT);
  assign is_fmax = !is_fw && !is_fh;
  assign check   = is_fmax || is_other;
  assign v0      = (phase == PH_NUMBER) ? acc : '0;
  assign w_fin   = is_fw ? v0 : width_store;
  assign h_fin   = is_fh ? v0 : (is_fw ? '0 : height_store);
  assign m_fin   = is_fmax ? v0 : '0;

  always_comb begin
    phase_next   = phase;
    field_next   = field;
    acc_next     = acc;
    width_next   = width_store;
    height_next  = height_store;
    remain_next  = remaining;
    hdr_emit     = 1'b0;
    pix_emit     = 1'b0;
    err_emit     = 1'b0;
    to_after_max = 1'b0;
    err_code     = ERR_NONE;

    if (take && file_bytes.end_of_stream) begin
      unique case (phase) inside
        PH_MAGIC1, PH_MAGIC2: begin
          err_emit = 1'b1;
          err_code = ERR_BAD_MAGIC;
        end
        PH_SKIP, PH_COMMENT, PH_NUMBER: begin
          err_emit = 1'b1;
          err_code = ERR_TRUNCATED;
        end
        PH_AFTER_MAX, PH_AFTER_CR, PH_DATA: begin
          err_emit = 1'b1;
          err_code = ERR_SHORT_DATA;
        end
        default: ;
      endcase
      phase_next  = PH_MAGIC1;
      field_next  = FLD_WIDTH;
      acc_next    = '0;
      width_next  = '0;
      height_next = '0;
      remain_next = '0;
    end else if (take) begin
      unique case (phase) inside
        PH_MAGIC1: begin
          if (b == CH_P) begin
            phase_next = PH_MAGIC2;
          end else begin
            err_emit   = 1'b1;
            err_code   = ERR_BAD_MAGIC;
            phase_next = PH_ERROR;
          end
        end
        PH_MAGIC2: begin
          if (b == CH_SIX) begin
            phase_next = PH_SKIP;
            field_next = FLD_WIDTH;
          end else begin
            err_emit   = 1'b1;
            err_code   = ERR_BAD_MAGIC;
            phase_next = PH_ERROR;
          end
        end
        PH_COMMENT: begin
          if (b == CH_LF) phase_next = PH_SKIP;
        end
        PH_SKIP, PH_NUMBER: begin
          if (phase == PH_NUMBER && is_digit) begin
            acc_next = acc_sat;
          end else if (is_digit) begin
            phase_next = PH_NUMBER;
            acc_next   = DIM_BITS'(digit);
          end else if (phase == PH_SKIP && is_hash) begin
            phase_next = PH_COMMENT;
          end else if (phase == PH_SKIP && is_ws) begin
            phase_next = PH_SKIP;
          end else begin
            // close the current field; a stray byte closes all remaining ones
            if (is_fw) width_next = v0;
            if (is_fh || (is_fw && check)) height_next = h_fin;
            if (!check) begin
              field_next = field + 2'd1;
              phase_next = is_hash ? PH_COMMENT : PH_SKIP;
            end else if (w_fin == '0) begin
              err_emit   = 1'b1;
              err_code   = ERR_BAD_WIDTH;
              phase_next = PH_ERROR;
            end else if (h_fin == '0) begin
              err_emit   = 1'b1;
              err_code   = ERR_BAD_HEIGHT;
              phase_next = PH_ERROR;
            end else if (m_fin != DIM_BITS'(MAXVAL_REQ)) begin
              err_emit   = 1'b1;
              err_code   = ERR_BAD_MAXVAL;
              phase_next = PH_ERROR;
            end else begin
              to_after_max = 1'b1;
            end
          end
        end
        PH_AFTER_MAX: to_after_max = 1'b1;
        PH_AFTER_CR: begin
          phase_next = PH_DATA;
          if (b != CH_LF) pix_emit = 1'b1;
        end
        PH_DATA: pix_emit = 1'b1;
        default: ;
      endcase

      if (to_after_max) begin
        hdr_emit = 1'b1;
        if (b == CH_LF) begin
          phase_next = PH_DATA;
        end else if (b == CH_CR) begin
          phase_next = PH_AFTER_CR;
        end else begin
          phase_next = PH_DATA;
          pix_emit   = 1'b1;
        end
      end
    end

    base = hdr_emit ? total : remaining;
    dec  = base - CNT_W'(1);
    if (pix_emit) begin
      remain_next = dec;
      if (dec == '0) phase_next = PH_DONE;
    end else if (hdr_emit) begin
      remain_next = total;
    end
  end

  always_comb begin
    op.has_header = hdr_emit;
    op.has_pixel  = pix_emit;
    op.has_error  = err_emit;
    op.err        = err_code;
    op.width      = 16'(width_store);
    op.height     = 16'(height_store);
    op.pixel      = b;
    op.last       = pix_emit && (dec == '0);
  end

  assign op_valid = hdr_emit || pix_emit || err_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_MAGIC1;
      field        <= FLD_WIDTH;
      acc          <= '0;
      width_store  <= '0;
      height_store <= '0;
      remaining    <= '0;
    end else begin
      phase        <= phase_next;
      field        <= field_next;
      acc          <= acc_next;
      width_store  <= width_next;
      height_store <= height_next;
      remaining    <= remain_next;
    end
  end

  // byte count of the image, settled well before the maximum value closes
  always_ff @(posedge clk) begin
    product <= PRD_W'(width_store) * PRD_W'(height_store);
    total   <= CNT_W'(product) + (CNT_W'(product) << 1);
  end

endmodule

// File: rtl/core/ppm_queue.sv
// ----------------------------------------------------------------------------
// ppm_queue
// Short register queue of parser operations between the parser and the
// result emitter.
// ----------------------------------------------------------------------------
module ppm_queue
  import ppm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_ready,
  input  ppm_op_t push_op,
  output logic    pop_valid,
  input  logic    pop_ready,
  output ppm_op_t pop_op
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ppm_op_t          entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_op;
  end

endmodule

// File: rtl/core/ppm_emit.sv
// ----------------------------------------------------------------------------
// ppm_emit
// Result emitter: turns each queued operation into one or two result items
// (header before its first pixel byte) and holds them in an output register.
// ----------------------------------------------------------------------------
module ppm_emit
  import ppm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      op_valid,
  output logic      op_ready,
  input  ppm_op_t   op,
  ppm_out_if.source results
);

  logic        out_valid;
  logic        hdr_sent;
  logic        load;
  logic        show_hdr;
  logic        split;
  kind_t       kind_d, kind_q;
  logic [15:0] width_d, width_q;
  logic [15:0] height_d, height_q;
  logic [7:0]  pixel_d, pixel_q;
  err_t        err_d, err_q;
  logic        last_d, last_q;

  assign load     = !out_valid || results.ready;
  assign show_hdr = op.has_header && !hdr_sent;
  assign split    = show_hdr && op.has_pixel;
  assign op_ready = load && !split;

  always_comb begin
    kind_d   = op.has_error ? KIND_ERROR : (show_hdr ? KIND_HEADER : KIND_PIXEL);
    width_d  = (show_hdr && !op.has_error) ? op.width : '0;
    height_d = (show_hdr && !op.has_error) ? op.height : '0;
    pixel_d  = (!show_hdr && !op.has_error) ? op.pixel : '0;
    last_d   = (!show_hdr && !op.has_error) ? op.last : 1'b0;
    err_d    = op.has_error ? op.err : ERR_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hdr_sent  <= 1'b0;
    end else if (load) begin
      out_valid <= op_valid;
      if (op_valid) hdr_sent <= split;
    end
  end

  always_ff @(posedge clk) begin
    if (load && op_valid) begin
      kind_q   <= kind_d;
      width_q  <= width_d;
      height_q <= height_d;
      pixel_q  <= pixel_d;
      err_q    <= err_d;
      last_q   <= last_d;
    end
  end

  assign results.valid        = out_valid;
  assign results.kind         = kind_q;
  assign results.frame_width  = width_q;
  assign results.frame_height = height_q;
  assign results.pixel_byte   = pixel_q;
  assign results.error_code   = err_q;
  assign results.last_pixel   = last_q;

endmodule

// File: rtl/core/ppm_p6_stream_parser.sv
// ----------------------------------------------------------------------------
// ppm_p6_stream_parser
// Binary PPM (P6) parser: checks the magic, reads width, height and maximum
// value, then passes the pixel bytes on, with error results and an
// end-of-stream item that rearms it.
//
//   channel     role    item
//   file_bytes  sink    in_byte, end_of_stream
//   results     source  kind, frame_width, frame_height, pixel_byte,
//                       error_code, last_pixel
//
// One byte is taken per cycle while the queue is not full; the parse state
// is registered as it is taken. A byte that gives both the header and the
// first pixel byte yields two results; QUEUE_DEPTH queue entries absorb it.
// file_bytes.ready falls only while that queue is full.
// rst clears the parse state, the queue and the output register at once.
// ----------------------------------------------------------------------------
module ppm_p6_stream_parser
  import ppm_pkg::*;
#(
  parameter int DIM_BITS    = DIM_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ppm_in_if.sink    file_bytes,
  ppm_out_if.source results
);

  logic    push_valid, push_ready;
  ppm_op_t push_op;
  logic    pop_valid, pop_ready;
  ppm_op_t pop_op;

  ppm_front #(
    .DIM_BITS (DIM_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .file_bytes (file_bytes),
    .op_valid   (push_valid),
    .op_ready   (push_ready),
    .op         (push_op)
  );

  ppm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  ppm_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .op_valid (pop_valid),
    .op_ready (pop_ready),
    .op       (pop_op),
    .results  (results)
  );

endmodule
